[design/lmcs_pkg.sv]
// Shared types and constants for the lamp matrix column scanner.
`default_nettype none

package lmcs_pkg;

  localparam int unsigned PATTERN_DEPTH = 8;
  localparam int unsigned ROW_W         = 8;
  localparam int unsigned IDX_W         = 3;

  localparam logic CMD_SCAN  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic PORT_COLUMN = 1'b0;
  localparam logic PORT_ROW    = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] column_index;
    logic [ROW_W-1:0] row_bits;
  } in_item_t;

  typedef struct packed {
    logic             port_select;
    logic [ROW_W-1:0] port_value;
    logic             frame_sync;
    logic             last_of_run;
  } out_item_t;

  // Shadow pattern write request.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [ROW_W-1:0] data;
  } pat_wr_t;

  // What one scan tick needs to drive its three port writes.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] col_onehot;
    logic             wrap;
  } scan_info_t;

endpackage

`default_nettype wire

[design/lmcs_pattern.sv]
// Shadow and active pattern storage with the scan column counter.
`default_nettype none

module lmcs_pattern
  import lmcs_pkg::*;
#(
  parameter int unsigned NUM_COLUMNS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire pat_wr_t    pat_wr,
  input  wire logic       tick,
  output      scan_info_t scan_info
);

  localparam int unsigned COL_W = $clog2(NUM_COLUMNS);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(NUM_COLUMNS - 1);

  logic [COL_W-1:0] scan_column_r;
  logic [COL_W-1:0] scan_column_nxt;
  logic [ROW_W-1:0] active_r [PATTERN_DEPTH];
  logic [ROW_W-1:0] shadow_r [PATTERN_DEPTH];
  logic [IDX_W-1:0] rd_idx;
  logic             wrap;

  assign rd_idx = IDX_W'(scan_column_r);
  assign wrap   = (scan_column_r == LAST_COL);

  assign scan_column_nxt = wrap ? '0 : scan_column_r + COL_W'(1);

  assign scan_info.row        = active_r[rd_idx];
  assign scan_info.col_onehot = ROW_W'(1) << rd_idx;
  assign scan_info.wrap       = wrap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_column_r <= '0;
      for (int i = 0; i < PATTERN_DEPTH; i++) begin
        active_r[i] <= '0;
        shadow_r[i] <= '0;
      end
    end else begin
      if (pat_wr.en) begin
        shadow_r[pat_wr.idx] <= pat_wr.data;
      end
      if (tick) begin
        scan_column_r <= scan_column_nxt;
        // copy the whole shadow at frame end
        if (wrap) begin
          for (int i = 0; i < PATTERN_DEPTH; i++) begin
            active_r[i] <= shadow_r[i];
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    scan_column_r <= LAST_COL)
    else $error("scan column beyond column count");

  a_wrap_to_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && wrap) |=> (scan_column_r == '0))
    else $error("scan column did not return to zero at frame end");
`endif

endmodule

`default_nettype wire

[design/lmcs_emit.sv]
// Result register that plays out the three port writes of one scan tick.
`default_nettype none

module lmcs_emit
  import lmcs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load,
  input  wire scan_info_t scan_info,
  output      logic       free,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      out_item_t  out_data
);

  typedef enum logic [1:0] {
    BEAT_BLANK,
    BEAT_ROW,
    BEAT_COL
  } beat_t;

  beat_t            beat_r;
  logic             valid_r;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] onehot_r;
  logic             wrap_r;
  logic             xfer;

  assign xfer      = valid_r && out_ready;
  assign free      = !valid_r || (out_ready && beat_r == BEAT_COL);
  assign out_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r  <= BEAT_BLANK;
    end else if (load) begin
      valid_r  <= 1'b1;
      beat_r   <= BEAT_BLANK;
      row_r    <= scan_info.row;
      onehot_r <= scan_info.col_onehot;
      wrap_r   <= scan_info.wrap;
    end else if (xfer) begin
      case (beat_r)
        BEAT_BLANK: beat_r <= BEAT_ROW;
        BEAT_ROW:   beat_r <= BEAT_COL;
        BEAT_COL: begin
          valid_r <= 1'b0;
          beat_r  <= BEAT_BLANK;
        end
        default: beat_r <= BEAT_BLANK;
      endcase
    end
  end

  always_comb begin
    case (beat_r)
      BEAT_BLANK: out_data = '{PORT_COLUMN, '0, 1'b0, 1'b0};
      BEAT_ROW:   out_data = '{PORT_ROW, row_r, 1'b0, 1'b0};
      BEAT_COL:   out_data = '{PORT_COLUMN, onehot_r, wrap_r, 1'b1};
      default:    out_data = '{PORT_COLUMN, '0, 1'b0, 1'b0};
    endcase
  end

`ifndef SYNTHESIS
  a_sync_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.frame_sync) |-> out_data.last_of_run)
    else $error("frame sync off the last write");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer && beat_r != BEAT_COL) |=> (out_valid && beat_r != BEAT_BLANK))
    else $error("tick run dropped before its last write");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("tick loaded over a pending run");
`endif

endmodule

`default_nettype wire

[design/lamp_matrix_column_scanner_top.sv]
// Top level of the lamp matrix column scanner.
`default_nettype none

// Double-buffered column scanner for a lamp matrix of NUM_COLUMNS columns by
// 8 rows. Each input transfer is either a pattern write (cmd = 1), which
// stores row_bits into the shadow pattern at column_index and gives no
// result, or a scan tick (cmd = 0), which gives three result transfers in
// order: column port blanked to zero, row port loaded with the active
// pattern byte of the current column, and column port set to the one-hot
// code of that column (last_of_run set). The column counter then advances;
// at its wrap the active pattern copies the shadow pattern and the third
// write carries frame_sync, so a new pattern shows from the next frame on.
// Timing: an input transfer is registered in an input register on
// acceptance. A pattern write retires from there at once, so writes sustain
// one per cycle while no scan tick is held ahead of them. A scan tick moves
// into the result register, which presents its three writes in order as
// out_ready takes them; the next tick can load as the third write is taken.
// The input register accepts while a run drains, until it holds a tick waiting
// for the result register; a tick passes the input register, then the result
// register. Reset clears both patterns (all lamps off) and the counter.

module lamp_matrix_column_scanner_top
  import lmcs_pkg::*;
#(
  parameter int unsigned NUM_COLUMNS = 8
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire in_item_t  in_data,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      out_item_t out_data
);

  in_item_t   stage_r;
  logic       stage_valid_r;
  logic       stage_consume;
  logic       emit_free;
  logic       tick;
  pat_wr_t    pat_wr;
  scan_info_t scan_info;

  // Retire a pattern write at once; hold a tick until the result register
  // can take a new run.
  assign stage_consume = stage_valid_r && (stage_r.cmd == CMD_WRITE || emit_free);
  assign in_ready      = !stage_valid_r || stage_consume;

  assign tick        = stage_valid_r && stage_r.cmd == CMD_SCAN && emit_free;
  assign pat_wr.en   = stage_valid_r && stage_r.cmd == CMD_WRITE;
  assign pat_wr.idx  = stage_r.column_index;
  assign pat_wr.data = stage_r.row_bits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid_r <= 1'b1;
      stage_r       <= in_data;
    end else if (stage_consume) begin
      stage_valid_r <= 1'b0;
    end
  end

  lmcs_pattern #(
    .NUM_COLUMNS(NUM_COLUMNS)
  ) u_pattern (
    .clk      (clk),
    .rst_n    (rst_n),
    .pat_wr   (pat_wr),
    .tick     (tick),
    .scan_info(scan_info)
  );

  lmcs_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (tick),
    .scan_info(scan_info),
    .free     (emit_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  a_write_retires: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_valid_r && stage_r.cmd == CMD_WRITE) |-> in_ready)
    else $error("pattern write held in input register");
`endif

endmodule

`default_nettype wire
